>>> rtl/rle_rgb565_sprite_decoder_macros.svh
// Assertion macros shared by the run-length sprite decoder RTL.
`ifndef RLE_RGB565_SPRITE_DECODER_MACROS_SVH
`define RLE_RGB565_SPRITE_DECODER_MACROS_SVH

// Property that must hold in every cycle outside reset.
`define RLE565_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that implies a consequence in the following cycle.
`define RLE565_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rle565_pkg.sv
// Types, constants and arithmetic helpers of the run-length sprite decoder.
package rle565_pkg;

  // Field widths.
  localparam int WordW    = 16;
  localparam int KindW    = 2;
  localparam int DestW    = 22;
  localparam int LenW     = 15;
  localparam int ChanW    = 8;
  localparam int RowW     = 16;
  localparam int WordsW   = 31;
  localparam int KeyW     = 17;
  localparam int ModeW    = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;

  // Addressing.
  localparam int IndexBits = 22;
  localparam int CoordBits = 16;
  localparam int CoordW    = (CoordBits < 16) ? CoordBits : 16;
  localparam int ColW      = 22;
  localparam logic [ColW-1:0] ColMax = {ColW{1'b1}};
  localparam int RowSumW   = ((RowW > CoordW) ? RowW : CoordW) + 1;
  localparam int ProdW     = RowSumW + CoordW;
  localparam int BaseW     = ColW + 1;
  localparam int IdxW      = ((ProdW > BaseW) ? ProdW : BaseW) + 1;

  // Queue between the front and the back end.
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegKey   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMode  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBlend = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPct   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegX     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegY     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegWidth = 3'd6;
  localparam logic [CfgIdxW-1:0] RegRows  = 3'd7;

  localparam logic [KeyW-1:0] KeyNone = 17'h10000;

  // Draw modes and blend kinds.
  localparam logic [ModeW-1:0] ModeHalf       = 8'd1;
  localparam logic [ModeW-1:0] ModeBlend      = 8'd2;
  localparam logic [ModeW-1:0] BlendPercent   = 8'd1;
  localparam logic [ModeW-1:0] BlendBright    = 8'd2;
  localparam logic [ModeW-1:0] BlendBrightAdd = 8'd3;
  localparam logic [ModeW-1:0] BlendInvert    = 8'd4;

  localparam logic [ChanW-1:0] AlphaOpaque = 8'd255;
  localparam logic [ChanW-1:0] AlphaHalf   = 8'd128;

  // Reciprocals for the constant divisions (scaled by 2^20, 2^16 and 2^24).
  localparam int Recip31  = 33826;
  localparam int Recip63  = 16645;
  localparam int Recip3   = 21846;
  localparam int Recip100 = 167773;

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_HIGH = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_COLOUR   = 2'd1,
    OP_RUN      = 2'd2,
    OP_KEY_LAST = 2'd3
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_NONE   = 2'd0,
    KIND_COLOUR = 2'd1,
    KIND_RUN    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ModeW-1:0]  show_mode;
    logic [ModeW-1:0]  blend_kind;
    logic [ModeW-1:0]  blend_pct;
    logic [CoordW-1:0] x_off;
    logic [CoordW-1:0] y_off;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] rows;
  } cfg_t;

  // One classified word, as handed from the front end to the back end.
  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] word;
    logic [RowW-1:0]  row_idx;
    logic             col_clear;
    logic             row_end;
    logic             image_end;
  } entry_t;

  // c * 255 / 31 for a 5-bit channel.
  function automatic logic [ChanW-1:0] expand5(input logic [4:0] c);
    logic [12:0] x;
    logic [28:0] m;
    x = 13'(c) * 13'd255;
    m = 29'(x) * 29'(Recip31);
    return m[27:20];
  endfunction

  // c * 255 / 63 for a 6-bit channel.
  function automatic logic [ChanW-1:0] expand6(input logic [5:0] c);
    logic [13:0] x;
    logic [28:0] m;
    x = 14'(c) * 14'd255;
    m = 29'(x) * 29'(Recip63);
    return m[27:20];
  endfunction

  // Mean of three channels, from their sum.
  function automatic logic [ChanW-1:0] avg3(input logic [9:0] s);
    logic [24:0] m;
    m = 25'(s) * 25'(Recip3);
    return m[23:16];
  endfunction

endpackage

>>> rtl/rle565_in_if.sv
// Word channel carrying the coded sprite stream into the decoder.
interface rle565_in_if;
  logic                          valid;
  logic                          ready;
  logic [rle565_pkg::WordW-1:0]  code_word;

  modport source (output valid, output code_word, input ready);
  modport sink (input valid, input code_word, output ready);
endinterface

>>> rtl/rle565_out_if.sv
// Word channel carrying decoded pixels and runs out of the decoder.
interface rle565_out_if;
  logic                          valid;
  logic                          ready;
  logic [rle565_pkg::KindW-1:0]  kind;
  logic [rle565_pkg::DestW-1:0]  dest_index;
  logic [rle565_pkg::LenW-1:0]   run_length;
  logic [rle565_pkg::ChanW-1:0]  red;
  logic [rle565_pkg::ChanW-1:0]  green;
  logic [rle565_pkg::ChanW-1:0]  blue;
  logic [rle565_pkg::ChanW-1:0]  alpha;
  logic                          row_end;
  logic                          image_end;
  logic                          index_overflow;

  modport source (
    output valid, output kind, output dest_index, output run_length,
    output red, output green, output blue, output alpha,
    output row_end, output image_end, output index_overflow,
    input ready
  );
  modport sink (
    input valid, input kind, input dest_index, input run_length,
    input red, input green, input blue, input alpha,
    input row_end, input image_end, input index_overflow,
    output ready
  );
endinterface

>>> rtl/rle565_front.sv
// Front end: accepts coded words, tracks row headers and classifies each word.
module rle565_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rle565_pkg::cfg_t    cfg_i,
  rle565_in_if.sink           code_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output rle565_pkg::entry_t  q_entry_o
);

  rle565_pkg::phase_e                  phase_q, phase_d;
  logic [rle565_pkg::WordW-1:0]        header_low_q, header_low_d;
  logic [rle565_pkg::WordsW-1:0]       words_left_q, words_left_d;
  logic [rle565_pkg::RowW-1:0]         row_index_q, row_index_d;
  logic                                run_pending_q, run_pending_d;

  logic                                accept;
  logic [rle565_pkg::WordsW-1:0]       half_count;
  logic [rle565_pkg::WordsW:0]         even_count;
  logic [rle565_pkg::WordsW-1:0]       hdr_words;
  logic                                hdr_empty;
  logic                                last_word;
  logic                                key_hit;
  logic                                finish;
  logic                                last_row;

  assign code_i.ready = !q_full_i;
  assign accept       = code_i.valid && !q_full_i;
  assign q_push_o     = accept;

  // Byte count halved and rounded up to even, less the two header words.
  assign half_count = {code_i.code_word, header_low_q[rle565_pkg::WordW-1:1]};
  assign even_count = {1'b0, half_count} + {{rle565_pkg::WordsW{1'b0}}, half_count[0]};
  assign hdr_words  = (even_count >= 32'd2) ? rle565_pkg::WordsW'(even_count - 32'd2) : '0;
  assign hdr_empty  = (hdr_words == '0);
  assign last_word  = (words_left_q == rle565_pkg::WordsW'(1));
  assign key_hit    = ({1'b0, code_i.code_word} == cfg_i.key);
  assign last_row   = ({1'b0, row_index_q} + 17'd1) >= 17'(cfg_i.rows);

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      rle565_pkg::PH_LOW: begin
        if (accept) phase_d = rle565_pkg::PH_HIGH;
      end
      rle565_pkg::PH_HIGH: begin
        if (accept) phase_d = hdr_empty ? rle565_pkg::PH_LOW : rle565_pkg::PH_DATA;
      end
      rle565_pkg::PH_DATA: begin
        if (accept && last_word) phase_d = rle565_pkg::PH_LOW;
      end
      default: begin
        if (accept) phase_d = rle565_pkg::PH_HIGH;
      end
    endcase
  end

  always_comb begin
    header_low_d  = header_low_q;
    words_left_d  = words_left_q;
    run_pending_d = run_pending_q;
    row_index_d   = row_index_q;
    finish        = 1'b0;
    q_entry_o.op        = rle565_pkg::OP_NONE;
    q_entry_o.word      = code_i.code_word;
    q_entry_o.row_idx   = row_index_q;
    q_entry_o.col_clear = 1'b0;
    q_entry_o.row_end   = 1'b0;
    q_entry_o.image_end = 1'b0;

    unique case (phase_q)
      rle565_pkg::PH_HIGH: begin
        words_left_d        = hdr_words;
        run_pending_d       = 1'b0;
        q_entry_o.col_clear = 1'b1;
        finish              = hdr_empty;
      end
      rle565_pkg::PH_DATA: begin
        if (run_pending_q) begin
          q_entry_o.op  = rle565_pkg::OP_RUN;
          run_pending_d = 1'b0;
        end else if (key_hit) begin
          if (!last_word) begin
            run_pending_d = 1'b1;
          end else begin
            q_entry_o.op = rle565_pkg::OP_KEY_LAST;
          end
        end else begin
          q_entry_o.op = rle565_pkg::OP_COLOUR;
        end
        words_left_d = words_left_q - rle565_pkg::WordsW'(1);
        finish       = last_word;
      end
      default: begin
        header_low_d = code_i.code_word;
      end
    endcase

    if (finish) begin
      q_entry_o.row_end   = 1'b1;
      q_entry_o.image_end = last_row;
      row_index_d         = last_row ? '0 : row_index_q + rle565_pkg::RowW'(1);
      run_pending_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= rle565_pkg::PH_LOW;
      header_low_q  <= '0;
      words_left_q  <= '0;
      row_index_q   <= '0;
      run_pending_q <= 1'b0;
    end else if (accept) begin
      phase_q       <= phase_d;
      header_low_q  <= header_low_d;
      words_left_q  <= words_left_d;
      row_index_q   <= row_index_d;
      run_pending_q <= run_pending_d;
    end
  end

endmodule

>>> rtl/rle565_queue.sv
// Short queue of classified words between the front and the back end.
module rle565_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rle565_pkg::entry_t  entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output rle565_pkg::entry_t  entry_o,
  output logic                empty_o
);

  rle565_pkg::entry_t                 mem_q [rle565_pkg::QDepth];
  logic [rle565_pkg::QPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [rle565_pkg::QCntW-1:0]       count_q;

  assign full_o  = (count_q == rle565_pkg::QCntW'(rle565_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  function automatic logic [rle565_pkg::QPtrW-1:0] wrap_inc(
    input logic [rle565_pkg::QPtrW-1:0] p
  );
    return (p == rle565_pkg::QPtrW'(rle565_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (pop_i) rd_ptr_q <= wrap_inc(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/rle565_back.sv
// Back end: places each word in the destination, expands colour and picks alpha.
module rle565_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rle565_pkg::cfg_t    cfg_i,
  input  rle565_pkg::entry_t  q_entry_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  rle565_out_if.source        pix_o
);

  // Column tracking.
  logic [rle565_pkg::ColW-1:0]     column_q, column_d;
  logic [rle565_pkg::LenW-1:0]     len;
  logic [rle565_pkg::ColW:0]       col_sum;
  logic [rle565_pkg::ColW-1:0]     col_next;
  logic [rle565_pkg::RowSumW-1:0]  row_sum;
  rle565_pkg::kind_e               kind_a;

  // Stage A: placement product, base and expanded colour.
  logic                            a_v_q;
  rle565_pkg::kind_e               a_kind_q;
  logic [rle565_pkg::ProdW-1:0]    a_prod_q;
  logic [rle565_pkg::BaseW-1:0]    a_base_q;
  logic [rle565_pkg::LenW-1:0]     a_len_q;
  logic [rle565_pkg::ChanW-1:0]    a_r_q, a_g_q, a_b_q;
  logic                            a_row_end_q, a_img_end_q, a_col_sat_q;

  // Stage B: output register.
  logic                            out_v_q;
  rle565_pkg::kind_e               out_kind_q;
  logic [rle565_pkg::DestW-1:0]    out_dest_q;
  logic [rle565_pkg::LenW-1:0]     out_len_q;
  logic [rle565_pkg::ChanW-1:0]    out_r_q, out_g_q, out_b_q, out_a_q;
  logic                            out_row_end_q, out_img_end_q, out_ovf_q;

  logic                            b_adv, a_adv, pop;
  logic [rle565_pkg::IdxW-1:0]     idx;
  logic                            place_b, colour_b, ovf_b;
  logic [9:0]                      chan_sum;
  logic [rle565_pkg::ChanW-1:0]    avg;
  logic [10:0]                     bright_x;
  logic [15:0]                     pct_x;
  logic [33:0]                     pct_m;
  logic [rle565_pkg::ChanW-1:0]    alpha_b;

  assign b_adv   = !out_v_q || pix_o.ready;
  assign a_adv   = !a_v_q || b_adv;
  assign pop     = !q_empty_i && a_adv;
  assign q_pop_o = pop;

  always_comb begin
    unique case (q_entry_i.op) inside
      rle565_pkg::OP_RUN: begin
        len    = q_entry_i.word[rle565_pkg::WordW-1:1];
        kind_a = rle565_pkg::KIND_RUN;
      end
      rle565_pkg::OP_KEY_LAST: begin
        len    = rle565_pkg::LenW'(1);
        kind_a = rle565_pkg::KIND_RUN;
      end
      rle565_pkg::OP_COLOUR: begin
        len    = rle565_pkg::LenW'(1);
        kind_a = rle565_pkg::KIND_COLOUR;
      end
      default: begin
        len    = '0;
        kind_a = rle565_pkg::KIND_NONE;
      end
    endcase
  end

  assign col_sum  = {1'b0, column_q} + (rle565_pkg::ColW + 1)'(len);
  assign col_next = (col_sum > {1'b0, rle565_pkg::ColMax}) ? rle565_pkg::ColMax
                                                           : col_sum[rle565_pkg::ColW-1:0];
  assign row_sum  = rle565_pkg::RowSumW'(q_entry_i.row_idx)
                  + rle565_pkg::RowSumW'(cfg_i.y_off);

  always_comb begin
    column_d = column_q;
    if (pop) begin
      if (q_entry_i.col_clear) begin
        column_d = '0;
      end else if (kind_a != rle565_pkg::KIND_NONE) begin
        column_d = col_next;
      end
      if (q_entry_i.row_end) column_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      a_v_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      column_q <= column_d;
      if (a_adv) a_v_q <= pop;
      if (b_adv) out_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_kind_q    <= kind_a;
      a_prod_q    <= rle565_pkg::ProdW'(row_sum) * rle565_pkg::ProdW'(cfg_i.width);
      a_base_q    <= rle565_pkg::BaseW'(column_q) + rle565_pkg::BaseW'(cfg_i.x_off);
      a_len_q     <= len;
      a_r_q       <= rle565_pkg::expand5(q_entry_i.word[15:11]);
      a_g_q       <= rle565_pkg::expand6(q_entry_i.word[10:5]);
      a_b_q       <= rle565_pkg::expand5(q_entry_i.word[4:0]);
      a_row_end_q <= q_entry_i.row_end;
      a_img_end_q <= q_entry_i.image_end;
      a_col_sat_q <= (column_q == rle565_pkg::ColMax);
    end
  end

  // Destination index and overflow.
  assign idx      = rle565_pkg::IdxW'(a_prod_q) + rle565_pkg::IdxW'(a_base_q);
  assign place_b  = (a_kind_q != rle565_pkg::KIND_NONE);
  assign colour_b = (a_kind_q == rle565_pkg::KIND_COLOUR);
  assign ovf_b    = (idx[rle565_pkg::IdxW-1:rle565_pkg::IndexBits] != '0) || a_col_sat_q;

  // Alpha candidates.
  assign chan_sum = 10'(a_r_q) + 10'(a_g_q) + 10'(a_b_q);
  assign avg      = rle565_pkg::avg3(chan_sum);
  assign bright_x = 11'(avg) * 11'd7;
  assign pct_x    = 16'(cfg_i.blend_pct) * 16'd255;
  assign pct_m    = 34'(pct_x) * 34'(rle565_pkg::Recip100);

  always_comb begin
    if (cfg_i.show_mode == rle565_pkg::ModeBlend) begin
      unique case (cfg_i.blend_kind)
        rle565_pkg::BlendPercent: begin
          alpha_b = (pct_m[33:24] > 10'd255) ? rle565_pkg::AlphaOpaque : pct_m[31:24];
        end
        rle565_pkg::BlendBright: begin
          alpha_b = avg;
        end
        rle565_pkg::BlendBrightAdd: begin
          alpha_b = (bright_x[10:2] > 9'd255) ? rle565_pkg::AlphaOpaque : bright_x[9:2];
        end
        rle565_pkg::BlendInvert: begin
          alpha_b = rle565_pkg::AlphaOpaque - avg;
        end
        default: begin
          alpha_b = rle565_pkg::AlphaOpaque;
        end
      endcase
    end else if (cfg_i.show_mode == rle565_pkg::ModeHalf) begin
      alpha_b = rle565_pkg::AlphaHalf;
    end else begin
      alpha_b = rle565_pkg::AlphaOpaque;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && a_v_q) begin
      out_kind_q    <= a_kind_q;
      out_dest_q    <= place_b ? rle565_pkg::DestW'(idx[rle565_pkg::IndexBits-1:0]) : '0;
      out_len_q     <= a_len_q;
      out_r_q       <= colour_b ? a_r_q : '0;
      out_g_q       <= colour_b ? a_g_q : '0;
      out_b_q       <= colour_b ? a_b_q : '0;
      out_a_q       <= colour_b ? alpha_b : '0;
      out_row_end_q <= a_row_end_q;
      out_img_end_q <= a_img_end_q;
      out_ovf_q     <= place_b && ovf_b;
    end
  end

  assign pix_o.valid          = out_v_q;
  assign pix_o.kind           = rle565_pkg::KindW'(out_kind_q);
  assign pix_o.dest_index     = out_dest_q;
  assign pix_o.run_length     = out_len_q;
  assign pix_o.red            = out_r_q;
  assign pix_o.green          = out_g_q;
  assign pix_o.blue           = out_b_q;
  assign pix_o.alpha          = out_a_q;
  assign pix_o.row_end        = out_row_end_q;
  assign pix_o.image_end      = out_img_end_q;
  assign pix_o.index_overflow = out_ovf_q;

endmodule

>>> rtl/rle_rgb565_sprite_decoder.sv
// Top level of the run-length RGB565 sprite decoder.
//
// The coded sprite arrives on code_i one 16-bit word per handshake; every word
// accepted there produces exactly one result word on pix_o, in order. Each
// row opens with two header words (low half first) giving the byte count of
// the row; the following data words are RGB565 pixels or transparent runs.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i, one
// register per write; the user must write it only while the decoder is idle,
// which the decoder itself does not enforce. The front end classifies each
// word in the cycle it is accepted and pushes it into a two-word queue. The
// back end pops one word a cycle while its stages can advance, into a stage
// that forms the row product and expands the colour, then into the output
// register where the index sum and alpha are settled. The decoder sustains
// one word per cycle while pix_o is ready, as set by the back-end column update.
// When the receiver stalls, the output register holds its word, the stage
// behind it fills and then the queue; code_i.ready falls only once the queue is
// full. Reset returns the header tracking to the start of an image, clears the
// column and row counters, disables the transparent key and sets opaque draw.
module rle_rgb565_sprite_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rle565_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rle565_pkg::CfgDataW-1:0]     cfg_data_i,
  rle565_in_if.sink                           code_i,
  rle565_out_if.source                        pix_o
);

`include "rle_rgb565_sprite_decoder_macros.svh"

  rle565_pkg::cfg_t    cfg_q;
  rle565_pkg::entry_t  push_entry;
  rle565_pkg::entry_t  pop_entry;
  logic                q_push, q_pop, q_full, q_empty;

  // Configuration registers; each write lands at the next clock edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key        <= rle565_pkg::KeyNone;
      cfg_q.show_mode  <= '0;
      cfg_q.blend_kind <= '0;
      cfg_q.blend_pct  <= '0;
      cfg_q.x_off      <= '0;
      cfg_q.y_off      <= '0;
      cfg_q.width      <= '0;
      cfg_q.rows       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rle565_pkg::RegKey:   cfg_q.key        <= cfg_data_i;
        rle565_pkg::RegMode:  cfg_q.show_mode  <= cfg_data_i[rle565_pkg::ModeW-1:0];
        rle565_pkg::RegBlend: cfg_q.blend_kind <= cfg_data_i[rle565_pkg::ModeW-1:0];
        rle565_pkg::RegPct:   cfg_q.blend_pct  <= cfg_data_i[rle565_pkg::ModeW-1:0];
        rle565_pkg::RegX:     cfg_q.x_off      <= cfg_data_i[rle565_pkg::CoordW-1:0];
        rle565_pkg::RegY:     cfg_q.y_off      <= cfg_data_i[rle565_pkg::CoordW-1:0];
        rle565_pkg::RegWidth: cfg_q.width      <= cfg_data_i[rle565_pkg::CoordW-1:0];
        rle565_pkg::RegRows:  cfg_q.rows       <= cfg_data_i[rle565_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Header tracking and word classification.
  rle565_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .code_i    (code_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (push_entry)
  );

  // Decouples the two halves so that a stalled receiver does not stop intake
  // until the queue has filled.
  rle565_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (pop_entry),
    .empty_o (q_empty)
  );

  // Placement, colour expansion, alpha and the output register.
  rle565_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_entry_i (pop_entry),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .pix_o     (pix_o)
  );

  // A header or key word places nothing in the destination.
  `RLE565_ASSERT(a_none_is_empty, !(pix_o.valid && pix_o.kind == rle565_pkg::KIND_NONE) || (pix_o.run_length == '0 && pix_o.dest_index == '0 && pix_o.index_overflow == 1'b0), "header word carries a placement")

  // The end of the image is always the end of a row.
  `RLE565_ASSERT(a_image_end_row, !(pix_o.valid && pix_o.image_end) || pix_o.row_end, "image end without row end")

  // A transparent run carries no colour.
  `RLE565_ASSERT(a_run_clear, !(pix_o.valid && pix_o.kind == rle565_pkg::KIND_RUN) || (pix_o.red == '0 && pix_o.green == '0 && pix_o.blue == '0 && pix_o.alpha == '0), "transparent run with colour")

  // The queue cannot fill itself from nothing.
  `RLE565_ASSERT_NEXT(a_queue_stays_empty, q_empty && !q_push, q_empty, "queue left empty state without a push")

endmodule
